>>> src/streaming_top_k_selector_top_macros.svh
`ifndef STREAMING_TOP_K_SELECTOR_TOP_MACROS_SVH
`define STREAMING_TOP_K_SELECTOR_TOP_MACROS_SVH

// concurrent check on clk, quiet while in reset
`define TKS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

>>> src/tks_pkg.sv
package tks_pkg;

	localparam int MAX_K_DEF       = 8;
	localparam int MAX_CLASSES_DEF = 1024;
	localparam int SCORE_W         = 16;
	localparam int INDEX_W         = 10;
	localparam int RANK_W          = 3;
	localparam int TOPK_W          = 4;
	localparam logic [TOPK_W-1:0] TOPK_RESET = 4'd5;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [RANK_W-1:0]  rank;
		logic [INDEX_W-1:0] class_index;
		logic [SCORE_W-1:0] best_score;
		logic               final_res;
	} result_t;

	typedef struct packed {
		logic               valid;
		logic [SCORE_W-1:0] score;
		logic [INDEX_W-1:0] index;
	} slot_t;

	function automatic logic half_is_nan(input logic [SCORE_W-1:0] h);
		return (h[14:10] == 5'h1f) && (h[9:0] != 10'd0);
	endfunction

	// -0 and +0 both give zero
	function automatic logic signed [SCORE_W:0] half_key(input logic [SCORE_W-1:0] h);
		logic signed [SCORE_W:0] mag;
		mag = {2'b00, h[14:0]};
		return h[15] ? -mag : mag;
	endfunction

endpackage

>>> src/tks_cell.sv
module tks_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ins_en,
	input  logic          clr,
	input  tks_pkg::slot_t new_slot,
	input  tks_pkg::slot_t prev_slot,
	input  logic          prev_beats,
	output tks_pkg::slot_t cur,
	output tks_pkg::slot_t nxt,
	output logic          beats
);
	import tks_pkg::*;

	logic          valid_q;
	logic [SCORE_W-1:0] score_q;
	logic [INDEX_W-1:0] index_q;

	assign cur = '{valid: valid_q, score: score_q, index: index_q};

	// strict compare keeps the earlier index ahead on ties
	assign beats = !valid_q || (half_key(new_slot.score) > half_key(score_q));

	always_comb begin
		nxt = cur;
		if (ins_en && beats) begin
			nxt = prev_beats ? prev_slot : new_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= clr ? 1'b0 : nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		score_q <= nxt.score;
		index_q <= nxt.index;
	end
endmodule

>>> src/streaming_top_k_selector_top.sv
// streaming top-k selector
// item channel: one fp16 score per request with a last flag, valid/stall.
// the scores of a frame are numbered from 0 in arrival order; a NaN takes an
// index but is never kept. a row of MAX_K cells holds the best pairs in
// descending order, and every cell compares the new score at once, so one
// score enters per cycle, with no gap unless a last request is stalled.
// on a last request the updated list is copied to an output shift row and the
// cells clear for the next frame. results leave one per cycle from there,
// unless result_stall holds them, rank 0 first, final_res on the last one; the
// first result passes through the output row and then the result register.
// the row stays busy while a frame's results drain; a new last request is
// stalled until the row is empty, other scores keep flowing.
// result_stall holds the result register and the output row in place.
// cfg channel writes top_k (always ready); 0 acts as 1, values above MAX_K
// act as MAX_K. reset empties the list, clears the counter, sets top_k to 5.
`include "streaming_top_k_selector_top_macros.svh"
module streaming_top_k_selector_top #(
	parameter int MAX_K       = tks_pkg::MAX_K_DEF,
	parameter int MAX_CLASSES = tks_pkg::MAX_CLASSES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  tks_pkg::item_t             item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output tks_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tks_pkg::TOPK_W-1:0] cfg_data
);
	import tks_pkg::*;

	localparam int CW = $clog2(MAX_CLASSES + 1);
	localparam int RW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

	logic [TOPK_W-1:0] top_k_q;
	logic [CW-1:0]     count_q;
	logic              accept, ins_en, clr;
	slot_t             new_slot;
	slot_t             cur   [MAX_K];
	slot_t             nxt   [MAX_K];
	logic              beats [MAX_K];
	slot_t             ds_q  [MAX_K];
	slot_t             ds_src[MAX_K];
	logic [MAX_K:0]    ds_valid;
	logic [RW-1:0]     rank_q;
	logic              pop;
	logic              result_valid_q;
	result_t           result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q <= TOPK_RESET;
		end else if (cfg_valid) begin
			top_k_q <= cfg_data;
		end
	end

	assign item_stall = ds_q[0].valid && item.last;
	assign accept     = item_valid && !item_stall;
	assign ins_en     = accept && (count_q < CW'(MAX_CLASSES)) && !half_is_nan(item.score);
	assign clr        = accept && item.last;
	assign new_slot   = '{valid: 1'b1, score: item.score, index: INDEX_W'(count_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (accept && (count_q < CW'(MAX_CLASSES))) begin
			count_q <= count_q + 1'b1;
		end
	end

	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		if (i == 0) begin : g_head
			tks_cell u_cell (
				.clk, .arst_n, .ins_en, .clr, .new_slot,
				.prev_slot('0), .prev_beats(1'b0),
				.cur(cur[i]), .nxt(nxt[i]), .beats(beats[i])
			);
		end else begin : g_body
			tks_cell u_cell (
				.clk, .arst_n, .ins_en, .clr, .new_slot,
				.prev_slot(cur[i-1]), .prev_beats(beats[i-1]),
				.cur(cur[i]), .nxt(nxt[i]), .beats(beats[i])
			);
		end
	end

	assign pop = ds_q[0].valid && (!result_valid_q || !result_stall);

	// output row: loaded from the updated list on last, shifts toward slot 0
	for (genvar i = 0; i < MAX_K; i++) begin : g_drain
		assign ds_valid[i] = ds_q[i].valid;
		if (i + 1 < MAX_K) begin : g_src
			assign ds_src[i] = ds_q[i+1];
		end else begin : g_end
			assign ds_src[i] = '0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ds_q[i] <= '0;
			end else if (clr) begin
				ds_q[i].valid <= nxt[i].valid && ((i == 0) || (i < int'(top_k_q)));
				ds_q[i].score <= nxt[i].score;
				ds_q[i].index <= nxt[i].index;
			end else if (pop) begin
				ds_q[i] <= ds_src[i];
			end
		end
	end
	assign ds_valid[MAX_K] = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (clr) begin
				rank_q <= '0;
			end else if (pop) begin
				rank_q <= rank_q + 1'b1;
			end
			if (pop) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.rank        <= RANK_W'(rank_q);
			result_q.class_index <= ds_q[0].index;
			result_q.best_score  <= ds_q[0].score;
			result_q.final_res   <= !ds_valid[1];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`TKS_ASSERT(a_last_clears_list, clr |=> !cur[0].valid, "list not cleared after last")
	`TKS_ASSERT(a_busy_blocks_last, (ds_q[0].valid && item_valid && item.last) |-> item_stall,
		"last request taken while results pending")
	`TKS_ASSERT(a_rank_restarts, (clr && !ds_q[0].valid) |=> (rank_q == '0),
		"rank counter did not restart on a new frame")
endmodule
